@@ design/esa_pkg.sv @@
// Shared types, codes and helper functions for the event spectrum accumulator.
`timescale 1ns / 1ps
package esa_pkg;

  localparam int NumBinsDef    = 4096;
  localparam int MaxComptonDef = 63;
  localparam int NumCounters   = 9;
  localparam int NumSums       = 7;
  localparam int QueueDepth    = 2;

  localparam logic [15:0] RST_BIN_WIDTH = 16'd1000;
  localparam logic [15:0] RST_TOL       = 16'd1000;

  // command codes
  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_PULSE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // outcome codes
  localparam logic [1:0] OUT_PHOTO  = 2'd0;
  localparam logic [1:0] OUT_CONV   = 2'd1;
  localparam logic [1:0] OUT_ESCAPE = 2'd2;

  // read spaces
  localparam logic [2:0] SP_ABS_HIST = 3'd0;
  localparam logic [2:0] SP_ALL_HIST = 3'd1;
  localparam logic [2:0] SP_DEP_SPEC = 3'd2;
  localparam logic [2:0] SP_LIT_SPEC = 3'd3;
  localparam logic [2:0] SP_COUNTERS = 3'd4;
  localparam logic [2:0] SP_SUMS     = 3'd5;

  // counter slots
  localparam int CNT_EVENTS    = 0;
  localparam int CNT_ABSORBED  = 1;
  localparam int CNT_CONV      = 2;
  localparam int CNT_ESCAPED   = 3;
  localparam int CNT_OTHER     = 4;
  localparam int CNT_FULL      = 5;
  localparam int CNT_OVF_EDEP  = 6;
  localparam int CNT_OVF_LIGHT = 7;
  localparam int CNT_WITH_EDEP = 8;

  // config register indexes
  localparam logic [7:0] CFG_BIN_WIDTH = 8'd0;
  localparam logic [7:0] CFG_TOLERANCE = 8'd1;

  typedef enum logic [1:0] {OP_EVENT, OP_PULSE, OP_READ} op_e;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EV_MUL, S_EV_UPD, S_DIV_GO, S_DIV_WAIT, S_SP_RD, S_SP_WR
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic        full;
    logic [1:0]  outcome;
    logic        per_pulse;
    logic [9:0]  compton;
    logic [23:0] edep;
    logic [23:0] light;
    logic [2:0]  read_space;
    logic [11:0] read_index;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic logic [31:0] inc_sat32(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic [63:0] add_sat64(input logic [63:0] s, input logic [63:0] v);
    logic [64:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[64] ? '1 : t[63:0];
  endfunction

endpackage

@@ design/esa_fifo.sv @@
// Two-entry item queue between the front and back parts.
`timescale 1ns / 1ps
module esa_fifo import esa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o,
  output logic  full_o
);

  item_t      mem_q [QueueDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'(QueueDepth));
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

@@ design/esa_front.sv @@
// Front part: accepts items, decodes the command and tests for full absorption.
`timescale 1ns / 1ps
module esa_front import esa_pkg::*; (
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   command_i,
  input  logic [9:0]   compton_count_i,
  input  logic [1:0]   outcome_i,
  input  logic [23:0]  edep_ev_i,
  input  logic [23:0]  light_ev_i,
  input  logic [23:0]  primary_energy_ev_i,
  input  logic         per_pulse_i,
  input  logic [2:0]   read_space_i,
  input  logic [11:0]  read_index_i,
  input  logic [23:0]  tolerance_i,
  input  back_status_t status_i,
  input  logic         q_full_i,
  output logic         push_o,
  output item_t        item_o
);

  logic [23:0] diff;
  logic        take;

  assign busy = q_full_i | status_i.clearing;
  assign take = start & ~busy;
  assign diff = (edep_ev_i > primary_energy_ev_i) ? edep_ev_i - primary_energy_ev_i
                                                  : primary_energy_ev_i - edep_ev_i;

  always_comb begin
    item_o.full       = diff < tolerance_i;
    item_o.outcome    = outcome_i;
    item_o.per_pulse  = per_pulse_i;
    item_o.compton    = compton_count_i;
    item_o.edep       = edep_ev_i;
    item_o.light      = light_ev_i;
    item_o.read_space = read_space_i;
    item_o.read_index = read_index_i;
    item_o.op         = OP_EVENT;
    push_o            = take;
    unique case (command_i)
      CMD_EVENT: item_o.op = OP_EVENT;
      CMD_PULSE: item_o.op = OP_PULSE;
      CMD_READ:  item_o.op = OP_READ;
      default:   push_o = 1'b0;  // unused command is dropped
    endcase
  end

endmodule

@@ design/esa_div.sv @@
// Restoring divider, one quotient bit per cycle, for the spectrum bin index.
`timescale 1ns / 1ps
module esa_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] num_i,
  input  logic [19:0] den_i,
  output logic        done_o,
  output logic [23:0] quot_o
);

  logic [23:0] num_q, quo_q;
  logic [19:0] rem_q, den_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [20:0] rs, sub;
  logic        ge;

  assign rs     = {rem_q, num_q[23]};
  assign ge     = rs >= {1'b0, den_q};
  assign sub    = rs - {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[22:0], 1'b0};
      rem_q <= ge ? sub[19:0] : rs[19:0];
      quo_q <= {quo_q[22:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'd23;
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/esa_back.sv @@
// Back part: sequencer that updates histograms, spectra, counters and sums.
`timescale 1ns / 1ps
module esa_back import esa_pkg::*; #(
  parameter int NUM_BINS    = NumBinsDef,
  parameter int MAX_COMPTON = MaxComptonDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [19:0]  bin_width_i,
  input  logic         q_empty_i,
  input  item_t        q_item_i,
  output logic         pop_o,
  output back_status_t status_o,
  output logic         result_valid_o,
  output logic [63:0]  read_data_o
);

  localparam int HistDepth = MAX_COMPTON + 1;
  localparam int HistAw    = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int BinAw     = $clog2(NUM_BINS);
  localparam int ClrN      = (NUM_BINS > HistDepth) ? NUM_BINS : HistDepth;
  localparam int ClrAw     = $clog2(ClrN);

  back_state_e state_q, state_d;
  item_t       item_q;
  logic [ClrAw-1:0] clr_q;
  logic        sel_light_q;
  logic [23:0] quot_q;
  logic [19:0] sq_c_q;
  logic [47:0] sq_l_q;
  logic [31:0] counters_q [NumCounters];
  logic [63:0] sums_q [NumSums];
  logic        valid_q;
  logic [63:0] data_q;

  logic [31:0] abs_mem [HistDepth];
  logic [31:0] all_mem [HistDepth];
  logic [31:0] dep_mem [NUM_BINS];
  logic [31:0] lit_mem [NUM_BINS];
  logic [31:0] abs_rd_q, all_rd_q, dep_rd_q, lit_rd_q;

  logic              div_start, div_done;
  logic [23:0]       div_quot, div_num;
  logic [19:0]       den;
  logic [HistAw-1:0] clamped, hist_raddr;
  logic [BinAw-1:0]  spec_raddr;
  logic [31:0]       idx32, q32;
  logic              clr_last, in_bins;

  assign den      = (bin_width_i == '0) ? 20'd1 : bin_width_i;
  assign div_num  = sel_light_q ? item_q.light : item_q.edep;
  assign clamped  = (32'(item_q.compton) > 32'(MAX_COMPTON)) ? HistAw'(MAX_COMPTON)
                                                              : HistAw'(item_q.compton);
  assign idx32    = 32'(item_q.read_index);
  assign q32      = 32'(quot_q);
  assign in_bins  = q32 < 32'(NUM_BINS);
  assign clr_last = (32'(clr_q) == 32'(ClrN - 1));

  assign hist_raddr = (item_q.op == OP_READ) ? idx32[HistAw-1:0] : clamped;
  assign spec_raddr = (item_q.op == OP_READ) ? idx32[BinAw-1:0] : q32[BinAw-1:0];

  assign status_o.clearing = (state_q == S_CLEAR);
  assign result_valid_o    = valid_q;
  assign read_data_o       = data_q;

  esa_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(den),
    .done_o(div_done), .quot_o(div_quot)
  );

  // next state
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      S_CLEAR: if (clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          unique case (q_item_i.op)
            OP_EVENT: state_d = S_EV_MUL;
            OP_PULSE: state_d = S_DIV_GO;
            default:  state_d = S_SP_RD;  // read: S_SP_RD waits for registered memory data
          endcase
        end
      end
      S_EV_MUL: state_d = S_EV_UPD;
      S_EV_UPD: state_d = item_q.per_pulse ? S_IDLE : S_DIV_GO;
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (div_done) state_d = S_SP_RD;
      S_SP_RD: state_d = S_SP_WR;
      S_SP_WR: begin
        if (item_q.op == OP_READ || sel_light_q) state_d = S_IDLE;
        else                                     state_d = S_DIV_GO;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  // memories: registered read every cycle, one write port each
  always_ff @(posedge clk_i) begin
    abs_rd_q <= abs_mem[hist_raddr];
    all_rd_q <= all_mem[hist_raddr];
    dep_rd_q <= dep_mem[spec_raddr];
    lit_rd_q <= lit_mem[spec_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      if (32'(clr_q) < 32'(HistDepth)) begin
        abs_mem[clr_q[HistAw-1:0]] <= '0;
        all_mem[clr_q[HistAw-1:0]] <= '0;
      end
    end else if (state_q == S_EV_UPD) begin
      if (item_q.outcome == OUT_PHOTO) abs_mem[clamped] <= inc_sat32(abs_rd_q);
      all_mem[clamped] <= inc_sat32(all_rd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      if (32'(clr_q) < 32'(NUM_BINS)) begin
        dep_mem[clr_q[BinAw-1:0]] <= '0;
        lit_mem[clr_q[BinAw-1:0]] <= '0;
      end
    end else if (state_q == S_SP_WR && item_q.op != OP_READ && in_bins) begin
      if (sel_light_q) lit_mem[q32[BinAw-1:0]] <= inc_sat32(lit_rd_q);
      else             dep_mem[q32[BinAw-1:0]] <= inc_sat32(dep_rd_q);
    end
  end

  // item payload and products
  always_ff @(posedge clk_i) begin
    if (pop_o) item_q <= q_item_i;
    if (state_q == S_EV_MUL) begin
      sq_c_q <= item_q.compton * item_q.compton;
      sq_l_q <= item_q.light * item_q.light;
    end
    if (state_q == S_DIV_WAIT && div_done) quot_q <= div_quot;
  end

  // control, counters, sums, result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      sel_light_q <= 1'b0;
      valid_q     <= 1'b0;
      data_q      <= '0;
      for (int i = 0; i < NumCounters; i++) counters_q[i] <= '0;
      for (int i = 0; i < NumSums; i++)     sums_q[i]     <= '0;
    end else begin
      valid_q <= 1'b0;
      if (state_q == S_CLEAR) clr_q <= clr_q + ClrAw'(1);
      if (pop_o) sel_light_q <= 1'b0;

      if (state_q == S_EV_UPD) begin
        counters_q[CNT_EVENTS] <= inc_sat32(counters_q[CNT_EVENTS]);
        unique case (item_q.outcome)
          OUT_PHOTO: begin
            counters_q[CNT_ABSORBED] <= inc_sat32(counters_q[CNT_ABSORBED]);
            sums_q[0] <= add_sat64(sums_q[0], 64'(item_q.compton));
            sums_q[1] <= add_sat64(sums_q[1], 64'(sq_c_q));
          end
          OUT_CONV:   counters_q[CNT_CONV]    <= inc_sat32(counters_q[CNT_CONV]);
          OUT_ESCAPE: counters_q[CNT_ESCAPED] <= inc_sat32(counters_q[CNT_ESCAPED]);
          default:    counters_q[CNT_OTHER]   <= inc_sat32(counters_q[CNT_OTHER]);
        endcase
        if (item_q.full) begin
          counters_q[CNT_FULL] <= inc_sat32(counters_q[CNT_FULL]);
          sums_q[5] <= add_sat64(sums_q[5], 64'(item_q.light));
          sums_q[6] <= add_sat64(sums_q[6], 64'(sq_l_q));
        end
        if (item_q.edep != '0) begin
          counters_q[CNT_WITH_EDEP] <= inc_sat32(counters_q[CNT_WITH_EDEP]);
          sums_q[2] <= add_sat64(sums_q[2], 64'(item_q.edep));
          sums_q[3] <= add_sat64(sums_q[3], 64'(item_q.light));
          sums_q[4] <= add_sat64(sums_q[4], 64'(sq_l_q));
        end
      end

      if (state_q == S_SP_WR) begin
        if (item_q.op == OP_READ) begin
          valid_q <= 1'b1;
          data_q  <= '0;
          unique case (item_q.read_space)
            SP_ABS_HIST: if (idx32 < 32'(HistDepth)) data_q <= 64'(abs_rd_q);
            SP_ALL_HIST: if (idx32 < 32'(HistDepth)) data_q <= 64'(all_rd_q);
            SP_DEP_SPEC: if (idx32 < 32'(NUM_BINS))  data_q <= 64'(dep_rd_q);
            SP_LIT_SPEC: if (idx32 < 32'(NUM_BINS))  data_q <= 64'(lit_rd_q);
            SP_COUNTERS: if (idx32 < 32'(NumCounters))
                           data_q <= 64'(counters_q[idx32[3:0]]);
            SP_SUMS:     if (idx32 < 32'(NumSums))
                           data_q <= sums_q[idx32[2:0]];
            default: ;
          endcase
        end else begin
          sel_light_q <= 1'b1;
          if (!in_bins) begin
            if (sel_light_q)
              counters_q[CNT_OVF_LIGHT] <= inc_sat32(counters_q[CNT_OVF_LIGHT]);
            else
              counters_q[CNT_OVF_EDEP]  <= inc_sat32(counters_q[CNT_OVF_EDEP]);
          end
        end
      end
    end
  end

endmodule

@@ design/event_spectrum_accumulator_top.sv @@
// Top level of the event spectrum accumulator: config registers and part wiring.
`timescale 1ns / 1ps
// Flow: a read item passes S_SP_RD and S_SP_WR before result_valid_o; an event
// item passes S_EV_MUL and S_EV_UPD, then, with binning, two bin-index divides
// (edep, light); a pulse item just the divides. The serial divider sets the rate.
// Two queued items let start be taken while the back part is still working.
// Reset: async, clears control, counters and sums, then a clearing pass over
// max(NUM_BINS, MAX_COMPTON+1) addresses (4096 by default) holds busy high.
module event_spectrum_accumulator_top import esa_pkg::*; #(
  parameter int NUM_BINS    = NumBinsDef,
  parameter int MAX_COMPTON = MaxComptonDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [9:0]  compton_count_i,
  input  logic [1:0]  outcome_i,
  input  logic [23:0] edep_ev_i,
  input  logic [23:0] light_ev_i,
  input  logic [23:0] primary_energy_ev_i,
  input  logic        per_pulse_i,
  input  logic [2:0]  read_space_i,
  input  logic [11:0] read_index_i,
  // result: one-cycle strobe, the receiver cannot stall
  output logic        result_valid_o,
  output logic [63:0] read_data_o,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  logic [19:0]  bin_width_q;
  logic [23:0]  tol_q;
  logic         push, pop, q_empty, q_full;
  item_t        front_item, q_item;
  back_status_t status;

  // config registers, always ready; unknown indexes are ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= 20'(RST_BIN_WIDTH);
      tol_q       <= 24'(RST_TOL);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_BIN_WIDTH) bin_width_q <= cfg_data_i[19:0];
      if (cfg_index_i == CFG_TOLERANCE) tol_q       <= cfg_data_i;
    end
  end

  esa_front u_front (
    .start, .busy,
    .command_i, .compton_count_i, .outcome_i, .edep_ev_i, .light_ev_i,
    .primary_energy_ev_i, .per_pulse_i, .read_space_i, .read_index_i,
    .tolerance_i(tol_q), .status_i(status), .q_full_i(q_full),
    .push_o(push), .item_o(front_item)
  );

  esa_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(front_item), .pop_i(pop),
    .item_o(q_item), .empty_o(q_empty), .full_o(q_full)
  );

  esa_back #(.NUM_BINS(NUM_BINS), .MAX_COMPTON(MAX_COMPTON)) u_back (
    .clk_i, .rst_ni,
    .bin_width_i(bin_width_q),
    .q_empty_i(q_empty), .q_item_i(q_item), .pop_o(pop),
    .status_o(status),
    .result_valid_o, .read_data_o
  );

endmodule
